### rtl/core/ktwm_pkg.sv
// Shared constants and types for the kerned text width meter.
package ktwm_pkg;

   localparam int KERN_DEPTH  = 256;
   localparam int KIDX_W      = (KERN_DEPTH > 1) ? $clog2(KERN_DEPTH) : 1;
   localparam int KCNT_W      = $clog2(KERN_DEPTH + 1);
   localparam int CSR_W       = 9;
   localparam int LIM_W       = (KCNT_W > CSR_W) ? KCNT_W : CSR_W;

   localparam int ADV_DEPTH   = 95;
   localparam int GIDX_W      = 7;
   localparam int CODE_W      = 8;
   localparam int ADV_W       = 16;
   localparam int WIDTH_W     = 32;
   localparam int KENT_W      = 2 * CODE_W + ADV_W;

   localparam logic [CODE_W-1:0] FIRST_CODE    = 8'd32;
   localparam logic [CODE_W-1:0] LAST_CODE     = 8'd126;
   localparam logic [CODE_W-1:0] FALLBACK_CODE = 8'd63;
   localparam logic [CODE_W-1:0] NO_CHAR       = 8'd0;

   typedef enum logic [1:0] {
      OP_WRITE_ADVANCE = 2'd0,
      OP_WRITE_KERN    = 2'd1,
      OP_MEASURE       = 2'd2,
      OP_NOP           = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADVANCE,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic              req_ready;
      logic              add_advance;
      logic              add_kern;
      logic              finish;
      logic [KIDX_W-1:0] kern_addr;
   } ctrl_type;

endpackage

### rtl/core/ktwm_channels.sv
// Channel interfaces: request, response and register write.
interface ktwm_req_if;
   import ktwm_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [1:0]               op;
   logic [7:0]               slot;
   logic signed [ADV_W-1:0]  advance_value;
   logic [CODE_W-1:0]        pair_first;
   logic [CODE_W-1:0]        pair_second;
   logic signed [ADV_W-1:0]  pair_amount;
   logic [CODE_W-1:0]        char_code;
   logic                     last_char;
   modport source (output valid, op, slot, advance_value, pair_first, pair_second,
                   pair_amount, char_code, last_char, input ready);
   modport sink   (input valid, op, slot, advance_value, pair_first, pair_second,
                   pair_amount, char_code, last_char, output ready);
endinterface

interface ktwm_rsp_if;
   import ktwm_pkg::*;
   logic               valid;
   logic               ready;
   logic [WIDTH_W-1:0] total_width;
   modport source (output valid, total_width, input ready);
   modport sink   (input valid, total_width, output ready);
endinterface

interface ktwm_csr_if;
   import ktwm_pkg::*;
   logic             valid;
   logic             ready;
   logic [CSR_W-1:0] wdata;
   modport source (output valid, wdata, input ready);
   modport sink   (input valid, wdata, output ready);
endinterface

### rtl/core/kerned_text_width_meter.sv
// Top level of the kerned text width meter: table loads, kerning scan, width accumulate.
//
//  channel   dir  payload                                          transaction
//  req_chan  in   op slot advance_value pair_* char_code last_char valid & ready
//  rsp_chan  out  total_width                                      valid & ready
//  csr_chan  in   wdata (kern_pairs_used)                          valid & ready
//
// Loads (op 0, op 1) and op 3 leave the FSM idle, so req_chan stays ready.
// A measured character steps through accept, advance add, kerning reads up to and
// including a match (at most min(kern_pairs_used, KERN_DEPTH) entries), finish.
// One kerning memory read per cycle; the single shared 32-bit adder adds advance and kerning.
// Reset clears running width, previous character, the register and the FSM, not the tables.
// A stalled response blocks only the next last character, in its final cycle.
module kerned_text_width_meter (
   input logic       clock,
   input logic       reset,
   ktwm_req_if.sink  req_chan,
   ktwm_rsp_if.source rsp_chan,
   ktwm_csr_if.sink  csr_chan
);
   import ktwm_pkg::*;

   logic [ADV_W-1:0]  adv_mem [ADV_DEPTH];
   logic [KENT_W-1:0] kern_mem [KERN_DEPTH];

   state_type          state_ff, state_in;
   ctrl_type           ctrl;
   logic [CSR_W-1:0]   kpu_ff;
   logic [CODE_W-1:0]  char_ff, prev_ff;
   logic               last_ff;
   logic [WIDTH_W-1:0] running_ff, running_in;
   logic [KIDX_W-1:0]  cnt_ff;
   logic [ADV_W-1:0]   adv_rd_ff;
   logic [KENT_W-1:0]  kern_rd_ff;
   logic               rsp_valid_ff;
   logic [WIDTH_W-1:0] rsp_data_ff;

   logic               req_fire;
   logic [CODE_W-1:0]  char_map;
   logic [GIDX_W-1:0]  glyph_addr;
   logic [LIM_W-1:0]   limit;
   logic [LIM_W-1:0]   cnt_next;
   logic               kern_hit;
   logic               scan_end;
   logic               rsp_free;
   logic [WIDTH_W-1:0] addend;

   assign req_fire   = req_chan.valid && ctrl.req_ready;
   assign char_map   = (req_chan.char_code < FIRST_CODE || req_chan.char_code > LAST_CODE)
                       ? FALLBACK_CODE : req_chan.char_code;
   assign glyph_addr = GIDX_W'(char_map - FIRST_CODE);
   assign limit      = (LIM_W'(kpu_ff) > LIM_W'(KERN_DEPTH)) ? LIM_W'(KERN_DEPTH)
                                                             : LIM_W'(kpu_ff);
   assign cnt_next   = LIM_W'(cnt_ff) + LIM_W'(1);
   assign kern_hit   = kern_rd_ff[KENT_W-1 -: CODE_W] == prev_ff &&
                       kern_rd_ff[ADV_W +: CODE_W] == char_ff;
   assign scan_end   = kern_hit || cnt_next >= limit;
   assign rsp_free   = !rsp_valid_ff || rsp_chan.ready;

   // Shared adder: glyph advance or kerning amount, both sign-extended.
   always_comb begin
      addend = '0;
      if (ctrl.add_advance) begin
         addend = {{(WIDTH_W-ADV_W){adv_rd_ff[ADV_W-1]}}, adv_rd_ff};
      end else if (ctrl.add_kern) begin
         addend = {{(WIDTH_W-ADV_W){kern_rd_ff[ADV_W-1]}}, kern_rd_ff[ADV_W-1:0]};
      end
      running_in = running_ff + addend;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire && op_type'(req_chan.op) == OP_MEASURE) begin
               state_in = ST_ADVANCE;
            end
         end
         ST_ADVANCE: begin
            if (prev_ff != NO_CHAR && limit != '0) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!last_ff || rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Controls per state.
   always_comb begin
      ctrl = '0;
      case (state_ff)
         ST_IDLE:    ctrl.req_ready = 1'b1;
         ST_ADVANCE: ctrl.add_advance = 1'b1;
         ST_SCAN: begin
            ctrl.add_kern  = kern_hit;
            ctrl.kern_addr = KIDX_W'(cnt_next);
         end
         ST_DONE:    ctrl.finish = !last_ff || rsp_free;
         default:    ctrl = '0;
      endcase
   end

   assign req_chan.ready    = ctrl.req_ready;
   assign csr_chan.ready    = 1'b1;
   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.total_width = rsp_data_ff;

   // Table memories: write on load transactions, registered reads.
   always_ff @(posedge clock) begin
      if (req_fire && op_type'(req_chan.op) == OP_WRITE_ADVANCE &&
          int'(req_chan.slot) < ADV_DEPTH) begin
         adv_mem[GIDX_W'(req_chan.slot)] <= req_chan.advance_value;
      end
      adv_rd_ff <= adv_mem[glyph_addr];
   end

   always_ff @(posedge clock) begin
      if (req_fire && op_type'(req_chan.op) == OP_WRITE_KERN &&
          int'(req_chan.slot) < KERN_DEPTH) begin
         kern_mem[KIDX_W'(req_chan.slot)] <= {req_chan.pair_first, req_chan.pair_second,
                                              req_chan.pair_amount};
      end
      kern_rd_ff <= kern_mem[ctrl.kern_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kpu_ff       <= '0;
         prev_ff      <= NO_CHAR;
         running_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_chan.valid) begin
            kpu_ff <= csr_chan.wdata;
         end
         if (ctrl.add_advance || ctrl.add_kern) begin
            running_ff <= running_in;
         end
         if (ctrl.finish && last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (ctrl.finish) begin
            if (last_ff) begin
               running_ff   <= '0;
               prev_ff      <= NO_CHAR;
            end else begin
               prev_ff <= char_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         char_ff <= char_map;
         last_ff <= req_chan.last_char;
      end
      if (state_ff == ST_ADVANCE) begin
         cnt_ff <= '0;
      end else if (state_ff == ST_SCAN) begin
         cnt_ff <= KIDX_W'(cnt_next);
      end
      if (ctrl.finish && last_ff) begin
         rsp_data_ff <= running_ff;
      end
   end

   // Scan runs only with a previous character and within the searched range.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN |-> prev_ff != NO_CHAR && LIM_W'(cnt_ff) < limit)
      else $error("kerning scan outside its range");

   // A stored previous character is always a printable code.
   assert property (@(posedge clock) disable iff (reset)
      prev_ff != NO_CHAR |-> prev_ff >= FIRST_CODE && prev_ff <= LAST_CODE)
      else $error("previous character out of range");

   // Finishing a string presents the result and clears the running state.
   assert property (@(posedge clock) disable iff (reset)
      ctrl.finish && last_ff |=> rsp_valid_ff && running_ff == '0 && prev_ff == NO_CHAR)
      else $error("string end did not emit result and clear state");

   // No new request while a character is still being measured.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ADVANCE |=> !ctrl.req_ready)
      else $error("request accepted during measurement");

endmodule
